// ===== src/mmte_pkg.sv =====
// ----------------------------------------------------------------------------
// mmte_pkg
// Shared types, codes and sizes for the multimap table engine.
// ----------------------------------------------------------------------------
package mmte_pkg;

  localparam int CAPACITY  = 32;
  localparam int DATA_BITS = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int TOTAL_W   = 7;

  localparam logic [2:0] ACT_ADD      = 3'd0;
  localparam logic [2:0] ACT_REMOVE   = 3'd1;
  localparam logic [2:0] ACT_LOOKUP   = 3'd2;
  localparam logic [2:0] ACT_DROP_ALL = 3'd3;
  localparam logic [2:0] ACT_COUNT    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RP_SCAN,
    S_SHIFT,
    S_CNT,
    S_EMIT,
    S_COMP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [DATA_BITS-1:0] wr_key;
    logic [DATA_BITS-1:0] wr_val;
    logic [IDX_W-1:0]     rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic [DATA_BITS-1:0] value;
    logic                 last;
    logic [TOTAL_W-1:0]   total;
  } result_t;

endpackage

// ===== src/mmte_store.sv =====
// ----------------------------------------------------------------------------
// mmte_store
// Pair store: key and value arrays with one write and one registered read.
// ----------------------------------------------------------------------------
module mmte_store (
  input  logic                          clk,
  input  mmte_pkg::mem_req_t            req,
  output logic [mmte_pkg::DATA_BITS-1:0] rd_key,
  output logic [mmte_pkg::DATA_BITS-1:0] rd_val
);

  logic [mmte_pkg::DATA_BITS-1:0] key_mem [mmte_pkg::CAPACITY];
  logic [mmte_pkg::DATA_BITS-1:0] val_mem [mmte_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      key_mem[req.wr_addr] <= req.wr_key;
      val_mem[req.wr_addr] <= req.wr_val;
    end
  end

  always_ff @(posedge clk) begin
    rd_key <= key_mem[req.rd_addr];
    rd_val <= val_mem[req.rd_addr];
  end

endmodule

// ===== src/mmte_seq.sv =====
// ----------------------------------------------------------------------------
// mmte_seq
// Sequencer: walks the store one slot at a time with a shared
// comparator, shifting or compacting entries and producing results.
// ----------------------------------------------------------------------------
module mmte_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_action,
  input  logic [mmte_pkg::DATA_BITS-1:0] in_key,
  input  logic [mmte_pkg::DATA_BITS-1:0] in_val,
  output mmte_pkg::mem_req_t             req,
  input  logic [mmte_pkg::DATA_BITS-1:0] rd_key,
  input  logic [mmte_pkg::DATA_BITS-1:0] rd_val,
  output logic                           res_valid,
  input  logic                           res_ready,
  output mmte_pkg::result_t              res
);

  localparam int IW = mmte_pkg::IDX_W;
  localparam int CW = mmte_pkg::CNT_W;
  localparam int DW = mmte_pkg::DATA_BITS;

  mmte_pkg::state_t state, state_next;
  logic [2:0]    act, act_next;
  logic [DW-1:0] key_r, key_r_next;
  logic [DW-1:0] val_r, val_r_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] ptr, ptr_next;
  logic [IW-1:0] wptr, wptr_next;
  logic [CW-1:0] hits, hits_next;
  logic [CW-1:0] remaining, remaining_next;
  logic          phase, phase_next;
  logic [1:0]    rstat, rstat_next;
  logic          rfound, rfound_next;
  logic [DW-1:0] rval, rval_next;

  logic          key_hit;
  logic          at_top;
  logic [CW-1:0] emit_total;

  assign key_hit    = (rd_key == key_r);
  assign at_top     = (CW'(ptr) == count - CW'(1));
  assign emit_total = (act == mmte_pkg::ACT_DROP_ALL) ? count - hits : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmte_pkg::S_IDLE;
      count <= '0;
      phase <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    act       <= act_next;
    key_r     <= key_r_next;
    val_r     <= val_r_next;
    ptr       <= ptr_next;
    wptr      <= wptr_next;
    hits      <= hits_next;
    remaining <= remaining_next;
    rstat     <= rstat_next;
    rfound    <= rfound_next;
    rval      <= rval_next;
  end

  always_comb begin
    state_next     = state;
    act_next       = act;
    key_r_next     = key_r;
    val_r_next     = val_r;
    count_next     = count;
    ptr_next       = ptr;
    wptr_next      = wptr;
    hits_next      = hits;
    remaining_next = remaining;
    phase_next     = phase;
    rstat_next     = rstat;
    rfound_next    = rfound;
    rval_next      = rval;

    in_ready    = 1'b0;
    req.wr_en   = 1'b0;
    req.wr_addr = ptr;
    req.wr_key  = rd_key;
    req.wr_val  = rd_val;
    req.rd_addr = ptr;
    res_valid   = 1'b0;
    res.status  = mmte_pkg::ST_OK;
    res.found   = 1'b0;
    res.value   = '0;
    res.last    = 1'b1;
    res.total   = mmte_pkg::TOTAL_W'(count);

    unique case (state)
      mmte_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act_next   = in_action;
          key_r_next = in_key;
          val_r_next = in_val;
          state_next = mmte_pkg::S_START;
        end
      end

      mmte_pkg::S_START: begin
        rstat_next  = mmte_pkg::ST_OK;
        rfound_next = 1'b0;
        rval_next   = '0;
        hits_next   = '0;
        phase_next  = 1'b0;
        case (act) inside
          mmte_pkg::ACT_ADD: begin
            if (count == CW'(mmte_pkg::CAPACITY)) begin
              rstat_next = mmte_pkg::ST_FULL;
            end else begin
              // Oldest pair sits at slot 0, so an add is an append.
              req.wr_en   = 1'b1;
              req.wr_addr = IW'(count);
              req.wr_key  = key_r;
              req.wr_val  = val_r;
              count_next  = count + CW'(1);
            end
            state_next = mmte_pkg::S_RESP;
          end
          mmte_pkg::ACT_REMOVE: begin
            if (count == '0) begin
              rstat_next = mmte_pkg::ST_NOT_FOUND;
              state_next = mmte_pkg::S_RESP;
            end else begin
              ptr_next   = IW'(count - CW'(1));
              state_next = mmte_pkg::S_RP_SCAN;
            end
          end
          mmte_pkg::ACT_LOOKUP, mmte_pkg::ACT_DROP_ALL: begin
            if (count == '0) begin
              rstat_next = mmte_pkg::ST_NOT_FOUND;
              state_next = mmte_pkg::S_RESP;
            end else begin
              ptr_next   = '0;
              state_next = mmte_pkg::S_CNT;
            end
          end
          default: begin
            state_next = mmte_pkg::S_RESP;
          end
        endcase
      end

      // Newest first search for the exact pair.
      mmte_pkg::S_RP_SCAN: begin
        phase_next = ~phase;
        if (phase) begin
          if (key_hit && (rd_val == val_r)) begin
            rfound_next = 1'b1;
            rval_next   = val_r;
            if (at_top) begin
              count_next = count - CW'(1);
              state_next = mmte_pkg::S_RESP;
            end else begin
              ptr_next   = ptr + IW'(1);
              state_next = mmte_pkg::S_SHIFT;
            end
          end else if (ptr == '0) begin
            rstat_next = mmte_pkg::ST_NOT_FOUND;
            state_next = mmte_pkg::S_RESP;
          end else begin
            ptr_next = ptr - IW'(1);
          end
        end
      end

      // Close the gap: each slot above the removed one moves down by one.
      mmte_pkg::S_SHIFT: begin
        phase_next = ~phase;
        if (phase) begin
          req.wr_en   = 1'b1;
          req.wr_addr = ptr - IW'(1);
          if (at_top) begin
            count_next = count - CW'(1);
            state_next = mmte_pkg::S_RESP;
          end else begin
            ptr_next = ptr + IW'(1);
          end
        end
      end

      // First pass counts matches so that the last mark and the final
      // total are known before the first result leaves.
      mmte_pkg::S_CNT: begin
        phase_next = ~phase;
        if (phase) begin
          if (key_hit) begin
            hits_next = hits + CW'(1);
          end
          if (at_top) begin
            ptr_next       = IW'(count - CW'(1));
            remaining_next = hits_next;
            if (hits_next == '0) begin
              rstat_next = mmte_pkg::ST_NOT_FOUND;
              state_next = mmte_pkg::S_RESP;
            end else begin
              state_next = mmte_pkg::S_EMIT;
            end
          end else begin
            ptr_next = ptr + IW'(1);
          end
        end
      end

      // Second pass, newest first, one result per matching slot.
      mmte_pkg::S_EMIT: begin
        res.total = mmte_pkg::TOTAL_W'(emit_total);
        if (!phase) begin
          phase_next = 1'b1;
        end else if (key_hit) begin
          res_valid = 1'b1;
          res.found = 1'b1;
          res.value = rd_val;
          res.last  = (remaining == CW'(1));
          if (res_ready) begin
            remaining_next = remaining - CW'(1);
            phase_next     = 1'b0;
            if (remaining == CW'(1)) begin
              if (act == mmte_pkg::ACT_DROP_ALL) begin
                ptr_next   = '0;
                wptr_next  = '0;
                state_next = mmte_pkg::S_COMP;
              end else begin
                state_next = mmte_pkg::S_IDLE;
              end
            end else begin
              ptr_next = ptr - IW'(1);
            end
          end
        end else begin
          phase_next = 1'b0;
          ptr_next   = ptr - IW'(1);
        end
      end

      // Compaction keeps the survivors in their order from slot 0 upwards.
      mmte_pkg::S_COMP: begin
        phase_next = ~phase;
        if (phase) begin
          if (!key_hit) begin
            req.wr_en   = 1'b1;
            req.wr_addr = wptr;
            wptr_next   = wptr + IW'(1);
          end
          if (at_top) begin
            count_next = count - hits;
            state_next = mmte_pkg::S_IDLE;
          end else begin
            ptr_next = ptr + IW'(1);
          end
        end
      end

      mmte_pkg::S_RESP: begin
        res_valid  = 1'b1;
        res.status = rstat;
        res.found  = rfound;
        res.value  = rval;
        if (res_ready) begin
          state_next = mmte_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = mmte_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/multimap_table_engine_top.sv =====
// Add, count, or a search of an empty store: the start state leads to the response state, then the output register.
// Remove pair: slots are searched newest first, then each slot above the match is shifted down.
// Lookup and remove all: a counting pass over the slots, then a newest-first
// pass giving one result per match; remove all adds a compaction pass.
// One item at a time: a new request is taken only once the last is done; the single store read port sets the pace.
// Synchronous reset empties the store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// multimap_table_engine_top
// Bounded multimap of key and value pairs with a registered result output.
// ----------------------------------------------------------------------------
module multimap_table_engine_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic               found,
  output logic signed [31:0] out_value,
  output logic               last,
  output logic [6:0]         pair_total,
  output logic               is_empty
);

  mmte_pkg::mem_req_t             req;
  logic [mmte_pkg::DATA_BITS-1:0] rd_key;
  logic [mmte_pkg::DATA_BITS-1:0] rd_val;
  logic                           res_valid;
  logic                           res_ready;
  mmte_pkg::result_t              res;
  mmte_pkg::result_t              res_hold;
  logic                           load;

  mmte_store u_store (
    .clk    (clk),
    .req    (req),
    .rd_key (rd_key),
    .rd_val (rd_val)
  );

  mmte_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (action),
    .in_key    (key),
    .in_val    (value),
    .req       (req),
    .rd_key    (rd_key),
    .rd_val    (rd_val),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: a new result is taken whenever the held one has gone.
  assign res_ready = !out_valid || out_ready;
  assign load      = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_hold <= res;
    end
  end

  assign status     = res_hold.status;
  assign found      = res_hold.found;
  assign out_value  = res_hold.value;
  assign last       = res_hold.last;
  assign pair_total = res_hold.total;
  assign is_empty   = (res_hold.total == '0);

endmodule

// ===== sim/tb_multimap_table_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multimap_table_engine_top
// Self-checking bench for the multimap table engine. A shadow copy of the
// pair store, kept newest first, works out every result each accepted
// request should produce. Directed requests come first, then random traffic
// built mostly from keys and pairs already held, with the store filled
// to capacity once and adds tried past it. Both handshakes idle at random,
// and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_multimap_table_engine_top;

  // Action codes the block does not define; they behave as a count.
  localparam logic [2:0] ACT_RSVD_5 = 3'd5;
  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;

  localparam logic [31:0] KEY_A = 32'h8000_0000;
  localparam logic [31:0] KEY_B = 32'h7fff_ffff;
  localparam logic [31:0] KEY_C = 32'h0000_0000;
  localparam logic [31:0] KEY_D = 32'hffff_ffff;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_ITEMS  = 75;
  localparam int FILL_AT       = 30;
  localparam int HOLD_AFTER    = 40;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

  typedef struct packed {
    logic [1:0]                     status;
    logic                           found;
    logic [mmte_pkg::DATA_BITS-1:0] value;
    logic                           last;
    logic [mmte_pkg::TOTAL_W-1:0]   total;
    logic                           empty;
  } mm_result_t;

  class multimap_scoreboard;
    logic [mmte_pkg::DATA_BITS-1:0] table_keys [mmte_pkg::CAPACITY];
    logic [mmte_pkg::DATA_BITS-1:0] table_values [mmte_pkg::CAPACITY];
    int                             table_pairs;
    mm_result_t                     awaited_results [$];
    int                             mismatches;
    int                             results_checked;
    int                             requests_noted;
    int                             full_adds;
    int                             widest_lookup;

    function new();
      table_pairs     = 0;
      mismatches      = 0;
      results_checked = 0;
      requests_noted  = 0;
      full_adds       = 0;
      widest_lookup   = 0;
    endfunction

    // Pair count and empty flag reflect the store after the whole operation.
    function void await_result(logic [1:0] st, logic hit,
                               logic [mmte_pkg::DATA_BITS-1:0] val, logic fin);
      mm_result_t r;
      r.status = st;
      r.found  = hit;
      r.value  = val;
      r.last   = fin;
      r.total  = mmte_pkg::TOTAL_W'(table_pairs);
      r.empty  = (table_pairs == 0);
      awaited_results = {awaited_results, r};
    endfunction

    function void remove_at(int idx);
      int i;
      for (i = idx; i + 1 < table_pairs; i++) begin
        table_keys[i]   = table_keys[i + 1];
        table_values[i] = table_values[i + 1];
      end
      table_pairs--;
    endfunction

    function void note_request(logic [2:0] act, logic [mmte_pkg::DATA_BITS-1:0] k,
                               logic [mmte_pkg::DATA_BITS-1:0] v);
      logic [mmte_pkg::DATA_BITS-1:0] hits [mmte_pkg::CAPACITY];
      int n_hits;
      int hit_at;
      int i;
      int j;
      requests_noted++;
      n_hits = 0;
      hit_at = -1;
      case (act)
        mmte_pkg::ACT_ADD: begin
          if (table_pairs >= mmte_pkg::CAPACITY) begin
            full_adds++;
            await_result(mmte_pkg::ST_FULL, 1'b0, '0, 1'b1);
          end else begin
            for (i = table_pairs; i > 0; i--) begin
              table_keys[i]   = table_keys[i - 1];
              table_values[i] = table_values[i - 1];
            end
            table_keys[0]   = k;
            table_values[0] = v;
            table_pairs++;
            await_result(mmte_pkg::ST_OK, 1'b0, '0, 1'b1);
          end
        end
        mmte_pkg::ACT_REMOVE: begin
          for (i = 0; i < table_pairs; i++)
            if (hit_at < 0 && table_keys[i] == k && table_values[i] == v)
              hit_at = i;
          if (hit_at >= 0) begin
            remove_at(hit_at);
            await_result(mmte_pkg::ST_OK, 1'b1, v, 1'b1);
          end else begin
            await_result(mmte_pkg::ST_NOT_FOUND, 1'b0, '0, 1'b1);
          end
        end
        mmte_pkg::ACT_LOOKUP, mmte_pkg::ACT_DROP_ALL: begin
          for (i = 0; i < table_pairs; i++)
            if (table_keys[i] == k) begin
              hits[n_hits] = table_values[i];
              n_hits = n_hits + 1;
            end
          if (act == mmte_pkg::ACT_DROP_ALL) begin
            j = 0;
            for (i = 0; i < table_pairs; i++)
              if (table_keys[i] != k) begin
                table_keys[j]   = table_keys[i];
                table_values[j] = table_values[i];
                j++;
              end
            table_pairs = j;
          end
          if (n_hits > widest_lookup)
            widest_lookup = n_hits;
          if (n_hits == 0)
            await_result(mmte_pkg::ST_NOT_FOUND, 1'b0, '0, 1'b1);
          else
            for (i = 0; i < n_hits; i++)
              await_result(mmte_pkg::ST_OK, 1'b1, hits[i], i == n_hits - 1);
        end
        default: await_result(mmte_pkg::ST_OK, 1'b0, '0, 1'b1);
      endcase
    endfunction

    function void check_result(mm_result_t got);
      mm_result_t want;
      results_checked++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("[%0t] result with nothing outstanding: %s=%0d found=%0d value=%h",
                   $time, "status", got.status, got.found, got.value,
                   "  last=%0d total=%0d empty=%0d", got.last, got.total, got.empty);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.value !== want.value || got.last !== want.last ||
            got.total !== want.total || got.empty !== want.empty) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("[%0t] result mismatch", $time);
            $display("  expected status=%0d found=%0d value=%h last=%0d total=%0d empty=%0d",
                     want.status, want.found, want.value, want.last, want.total,
                     want.empty);
            $display("  actual   status=%0d found=%0d value=%h last=%0d total=%0d empty=%0d",
                     got.status, got.found, got.value, got.last, got.total,
                     got.empty);
          end
        end
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [2:0]         action    = mmte_pkg::ACT_COUNT;
  logic signed [31:0] key       = '0;
  logic signed [31:0] value     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         status;
  logic               found;
  logic signed [31:0] out_value;
  logic               last;
  logic [6:0]         pair_total;
  logic               is_empty;

  int                 cycle_count = 0;
  int                 burst_left  = 0;
  multimap_scoreboard board;

  multimap_table_engine_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found      (found),
    .out_value  (out_value),
    .last       (last),
    .pair_total (pair_total),
    .is_empty   (is_empty)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready)
      board.check_result({status, found, out_value, last, pair_total, is_empty});
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, board.awaited_results.size());
    $display("** multimap_table_engine_top: FAILED **");
    $finish;
  end

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0: return KEY_A;
      1: return KEY_B;
      2: return KEY_C;
      3: return KEY_D;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Called at a rising edge. The sender works in bursts; valid is only
  // lowered when a gap follows, so it never drops between back-to-back transfers.
  task automatic offer_item(input logic [2:0] act, input logic [31:0] k,
                            input logic [31:0] v);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(0, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    board.note_request(act, k, v);
  endtask

  initial begin : receiver
    flow_t stall_mode;
    int    phase;
    bit    held_off;
    stall_mode = FLOW_FREE;
    phase      = 0;
    held_off   = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held_off && board.results_checked >= HOLD_AFTER) begin
        // Long hold-off: the sender keeps offering, so the block backs up.
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (phase % 48 == 0)
          stall_mode = flow_t'($urandom_range(0, 3));
        phase++;
        case (stall_mode)
          FLOW_FREE:  out_ready <= 1'b1;
          FLOW_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
          FLOW_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= (phase % 5 < 2);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [2:0]  act;
    logic [31:0] k;
    logic [31:0] v;
    int          n;
    int          r;
    int          idx;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Empty store: every operation that searches must miss.
    offer_item(mmte_pkg::ACT_COUNT, KEY_C, KEY_C);
    offer_item(mmte_pkg::ACT_LOOKUP, KEY_C, KEY_C);
    offer_item(mmte_pkg::ACT_DROP_ALL, KEY_C, KEY_C);
    offer_item(mmte_pkg::ACT_REMOVE, KEY_C, KEY_C);
    offer_item(mmte_pkg::ACT_ADD, KEY_A, 32'h7fff_ffff);
    offer_item(mmte_pkg::ACT_ADD, KEY_B, 32'h8000_0000);
    offer_item(mmte_pkg::ACT_ADD, KEY_D, 32'h0000_0000);
    offer_item(mmte_pkg::ACT_ADD, KEY_A, 32'hffff_ffff);
    offer_item(mmte_pkg::ACT_ADD, KEY_A, 32'h0000_0001);
    offer_item(mmte_pkg::ACT_LOOKUP, KEY_A, 32'h1234_5678);
    // Key present but value absent, then a match in the middle of the key's run.
    offer_item(mmte_pkg::ACT_REMOVE, KEY_A, 32'h1234_5678);
    offer_item(mmte_pkg::ACT_REMOVE, KEY_A, 32'hffff_ffff);
    offer_item(mmte_pkg::ACT_LOOKUP, KEY_A, 32'h0);
    offer_item(ACT_RSVD_5, KEY_A, 32'h5555_5555);
    offer_item(ACT_RSVD_6, KEY_B, 32'haaaa_aaaa);
    offer_item(ACT_RSVD_7, KEY_D, 32'hffff_ffff);
    offer_item(mmte_pkg::ACT_DROP_ALL, KEY_A, 32'h0);
    offer_item(mmte_pkg::ACT_LOOKUP, KEY_A, 32'h0);
    offer_item(mmte_pkg::ACT_COUNT, KEY_B, 32'h0);
    offer_item(mmte_pkg::ACT_REMOVE, KEY_B, 32'h8000_0000);
    offer_item(mmte_pkg::ACT_REMOVE, KEY_D, 32'h0000_0000);
    offer_item(mmte_pkg::ACT_COUNT, KEY_D, 32'hffff_ffff);
    offer_item(mmte_pkg::ACT_ADD, KEY_C, KEY_C);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == FILL_AT) begin
        // Fill to capacity on two keys, try to add past full, then read and
        // empty KEY_A so a lookup returns a long run of values.
        while (board.table_pairs < mmte_pkg::CAPACITY)
          offer_item(mmte_pkg::ACT_ADD, ($urandom_range(0, 2) == 0) ? KEY_C : KEY_A,
                     pick_value());
        offer_item(mmte_pkg::ACT_ADD, pick_key(), pick_value());
        offer_item(mmte_pkg::ACT_ADD, KEY_A, pick_value());
        offer_item(mmte_pkg::ACT_LOOKUP, KEY_A, pick_value());
        offer_item(mmte_pkg::ACT_COUNT, pick_key(), pick_value());
        idx = $urandom_range(0, mmte_pkg::CAPACITY - 1);
        offer_item(mmte_pkg::ACT_REMOVE, board.table_keys[idx], board.table_values[idx]);
        offer_item(mmte_pkg::ACT_ADD, KEY_C, pick_value());
        offer_item(mmte_pkg::ACT_ADD, KEY_C, pick_value());
        offer_item(mmte_pkg::ACT_DROP_ALL, KEY_A, pick_value());
        offer_item(mmte_pkg::ACT_LOOKUP, KEY_C, pick_value());
      end
      // Mostly reuse a stored pair so removals and lookups find something.
      if (board.table_pairs > 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, board.table_pairs - 1);
        k = board.table_keys[idx];
        v = board.table_values[idx];
      end else begin
        k = pick_key();
        v = pick_value();
      end
      r = $urandom_range(0, 99);
      if (r < 38) begin
        act = mmte_pkg::ACT_ADD;
        v   = pick_value();
      end else if (r < 55) begin
        act = mmte_pkg::ACT_REMOVE;
        if ($urandom_range(0, 4) == 0)
          v = pick_value();
      end else if (r < 75) begin
        act = mmte_pkg::ACT_LOOKUP;
      end else if (r < 85) begin
        act = mmte_pkg::ACT_DROP_ALL;
      end else if (r < 94) begin
        act = mmte_pkg::ACT_COUNT;
      end else begin
        case ($urandom_range(0, 2))
          0:       act = ACT_RSVD_5;
          1:       act = ACT_RSVD_6;
          default: act = ACT_RSVD_7;
        endcase
      end
      offer_item(act, k, v);
    end
    in_valid <= 1'b0;

    while (board.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d requests over every action code and %0d results,",
             board.requests_noted, board.results_checked);
    $display("a full store (%0d adds refused) and lookups of up to %0d values.",
             board.full_adds, board.widest_lookup);
    $display("Mismatches: %0d, results outstanding: %0d.", board.mismatches,
             board.awaited_results.size());
    if (board.mismatches == 0 && board.awaited_results.size() == 0)
      $display("** multimap_table_engine_top: PASSED **");
    else
      $display("** multimap_table_engine_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mmte_pkg.sv
src/mmte_store.sv
src/mmte_seq.sv
src/multimap_table_engine_top.sv
sim/tb_multimap_table_engine_top.sv
